>>> src/mmrn_pkg.sv
package mmrn_pkg;

    localparam int A_DEPTH_DEFAULT = 1024;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int STEP_CNT_W = $clog2(DATA_W);

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FLAT = 2'd1;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic req_ready;
        logic finish_go;
        logic mul_step;
        logic div_step;
        logic step_last;
    } ctrl_t;

endpackage

>>> src/minmax_range_normalizer_top.sv
// A fetch passes through a memory read, 32 multiply steps, 32 divide steps and the
// output register before its item is given; a fetch before both sets are loaded or
// when set A is flat goes straight to the output register.
// No request is taken while a fetch is in the bit-serial shift-add multiplier, the
// restoring divider or waiting for the output; loads are taken every cycle while idle.
// Reset (rst_n, asynchronous, active low) clears counts, flags and min/max values.
module minmax_range_normalizer_top
    import mmrn_pkg::*;
#(
    parameter int A_DEPTH = A_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] sample,
    input  logic               final_req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [31:0] result,
    output logic               end_of_set,
    output logic [1:0]         status
);

    localparam int AW = $clog2(A_DEPTH);
    localparam int CW = $clog2(A_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(A_DEPTH);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0] a_mem [A_DEPTH];

    state_t state_reg, state_next;
    ctrl_t ctrl;

    logic [CW-1:0] a_count_reg;
    logic [CW-1:0] read_index_reg;
    logic signed [DATA_W-1:0] a_min_reg, a_max_reg, b_min_reg, b_max_reg;
    logic a_done_reg, b_done_reg, a_ovf_reg, b_seen_reg;
    logic rsp_valid_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;

    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] mul_reg;
    logic [DATA_W-1:0] da_reg, db_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] res_reg;
    logic eos_reg;
    logic [1:0] status_reg;
    logic [DATA_W-1:0] result_reg;
    logic end_of_set_reg;
    logic [1:0] status_out_reg;

    logic accept;
    logic fetch_ok, flat;
    logic [CW-1:0] fetch_idx;
    logic fetch_eos;
    logic [CW-1:0] a_cnt_eff;
    logic a_start_new, b_seen_eff;
    logic signed [DATA_W:0] off_wide, da_wide, db_wide;
    logic [DATA_W:0] div_shift, div_sub;

    assign accept = req_valid && ctrl.req_ready;
    assign fetch_ok = a_done_reg && b_done_reg && (a_count_reg != '0);
    assign flat = (a_max_reg == a_min_reg);
    assign fetch_idx = (read_index_reg >= a_count_reg) ? '0 : read_index_reg;
    assign fetch_eos = ((fetch_idx + 1'b1) >= a_count_reg);
    assign a_start_new = a_done_reg;
    assign a_cnt_eff = a_start_new ? '0 : a_count_reg;
    assign b_seen_eff = b_done_reg ? 1'b0 : b_seen_reg;

    assign off_wide = $signed({rd_data_reg[DATA_W-1], rd_data_reg})
                      - $signed({a_min_reg[DATA_W-1], a_min_reg});
    assign da_wide = $signed({a_max_reg[DATA_W-1], a_max_reg})
                     - $signed({a_min_reg[DATA_W-1], a_min_reg});
    assign db_wide = $signed({b_max_reg[DATA_W-1], b_max_reg})
                     - $signed({b_min_reg[DATA_W-1], b_min_reg});

    assign div_shift = {acc_reg[PROD_W-1:DATA_W], acc_reg[DATA_W-1]};
    assign div_sub = div_shift - {1'b0, da_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.mul_step)
        begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                       + (mul_reg[DATA_W-1] ? {{DATA_W{1'b0}}, db_reg} : '0);
        end
        else if (ctrl.div_step)
        begin
            if (!div_sub[DATA_W])
            begin
                acc_next = {div_sub[DATA_W-1:0], acc_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                acc_next = {div_shift[DATA_W-1:0], acc_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        ctrl.req_ready = (state_reg == ST_IDLE);
        ctrl.finish_go = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);
        ctrl.mul_step = (state_reg == ST_MUL);
        ctrl.div_step = (state_reg == ST_DIV);
        ctrl.step_last = (cnt_reg == STEP_LAST);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_FETCH)
                begin
                    if (fetch_ok && !flat)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (ctrl.step_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ctrl.step_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (ctrl.finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_count_reg <= '0;
            read_index_reg <= '0;
            a_min_reg <= '0;
            a_max_reg <= '0;
            b_min_reg <= '0;
            b_max_reg <= '0;
            a_done_reg <= 1'b0;
            b_done_reg <= 1'b0;
            a_ovf_reg <= 1'b0;
            b_seen_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (ctrl.mul_step || ctrl.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (ctrl.finish_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (accept && action == ACT_LOAD_A)
            begin
                a_done_reg <= final_req;
                if (a_start_new)
                begin
                    read_index_reg <= '0;
                end
                if (a_cnt_eff < DEPTH_C)
                begin
                    a_ovf_reg <= a_start_new ? 1'b0 : a_ovf_reg;
                    a_count_reg <= a_cnt_eff + 1'b1;
                    if (a_cnt_eff == '0)
                    begin
                        a_min_reg <= sample;
                        a_max_reg <= sample;
                    end
                    else
                    begin
                        if (sample < a_min_reg)
                        begin
                            a_min_reg <= sample;
                        end
                        if (sample > a_max_reg)
                        begin
                            a_max_reg <= sample;
                        end
                    end
                end
                else
                begin
                    a_ovf_reg <= 1'b1;
                    a_count_reg <= a_cnt_eff;
                end
            end

            if (accept && action == ACT_LOAD_B)
            begin
                b_done_reg <= final_req;
                b_seen_reg <= 1'b1;
                if (!b_seen_eff)
                begin
                    b_min_reg <= sample;
                    b_max_reg <= sample;
                end
                else
                begin
                    if (sample < b_min_reg)
                    begin
                        b_min_reg <= sample;
                    end
                    if (sample > b_max_reg)
                    begin
                        b_max_reg <= sample;
                    end
                end
            end

            if (accept && action == ACT_FETCH && fetch_ok)
            begin
                read_index_reg <= fetch_eos ? '0 : fetch_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_LOAD_A && a_cnt_eff < DEPTH_C)
        begin
            a_mem[a_cnt_eff[AW-1:0]] <= sample;
        end

        if (accept && action == ACT_FETCH)
        begin
            rd_data_reg <= a_mem[fetch_idx[AW-1:0]];
            eos_reg <= fetch_ok && fetch_eos;
            if (!fetch_ok)
            begin
                res_reg <= '0;
                status_reg <= STATUS_NOT_LOADED;
            end
            else if (flat)
            begin
                res_reg <= b_min_reg;
                status_reg <= STATUS_FLAT;
            end
            else
            begin
                status_reg <= a_ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
            end
        end

        if (state_reg == ST_READ)
        begin
            mul_reg <= off_wide[DATA_W-1:0];
            da_reg <= da_wide[DATA_W-1:0];
            db_reg <= db_wide[DATA_W-1:0];
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (ctrl.mul_step)
            begin
                mul_reg <= {mul_reg[DATA_W-2:0], 1'b0};
            end
        end

        if (ctrl.div_step && ctrl.step_last)
        begin
            res_reg <= b_min_reg + acc_next[DATA_W-1:0];
        end

        if (ctrl.finish_go)
        begin
            result_reg <= res_reg;
            end_of_set_reg <= eos_reg;
            status_out_reg <= status_reg;
        end
    end

    assign req_ready = ctrl.req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign result = result_reg;
    assign end_of_set = end_of_set_reg;
    assign status = status_out_reg;

endmodule
